/* rtl/core/dbd_pkg.sv */
// ----------------------------------------------------------------------------
// dbd_pkg
// shared types and constants of the detection box decode unit
// ----------------------------------------------------------------------------
package dbd_pkg;

	localparam int MAX_CLASSES = 128;

	// configuration register indexes
	localparam logic [2:0] CFG_MIN_SCORE    = 3'd0;
	localparam logic [2:0] CFG_INV_SCALE    = 3'd1;
	localparam logic [2:0] CFG_PAD_X        = 3'd2;
	localparam logic [2:0] CFG_PAD_Y        = 3'd3;
	localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd4;
	localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd5;
	localparam logic [2:0] CFG_CLASS_COUNT  = 3'd6;
	localparam logic [2:0] CFG_BOX_LIMIT    = 3'd7;

	// queue depths, pointers are two bits wide
	localparam int JOB_DEPTH = 4;
	localparam int BOX_DEPTH = 4;

	// corner arithmetic widths
	localparam int DW  = 35;  // corner at Q.13 minus padding
	localparam int PPW = 42;  // partial product width
	localparam int PW  = 60;  // full product width

	typedef struct packed {
		logic [12:0] min_score;
		logic [23:0] inv_scale;
		logic [11:0] pad_x;
		logic [11:0] pad_y;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [7:0]  class_count;
		logic [15:0] box_limit;
	} cfg_t;

	// a row that passed the score test and the box limit
	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] box_width;
		logic signed [31:0] box_height;
		logic [12:0]        best_score;
		logic [6:0]         class_label;
	} job_t;

	typedef struct packed {
		logic [23:0] left;
		logic [23:0] top;
		logic [23:0] right;
		logic [23:0] bottom;
		logic [12:0] best_score;
		logic [6:0]  class_label;
	} box_t;

endpackage

/* rtl/core/dbd_front.sv */
// ----------------------------------------------------------------------------
// dbd_front
// row parser: captures box values, tracks the best class, issues box jobs
// ----------------------------------------------------------------------------
module dbd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_beat,
	input  logic signed [31:0] value,
	input  logic               frame_start,
	input  dbd_pkg::cfg_t      cfg,
	output logic               job_valid,
	output dbd_pkg::job_t      job
);

	logic [7:0]         row_pos_q;
	logic [15:0]        boxes_q;
	logic signed [31:0] cx_q, cy_q, w_q, h_q, run_max_q;
	logic [6:0]         run_label_q;

	logic [7:0]         pos, k, cc, cc_m1;
	logic [15:0]        cnt;
	logic               is_box, take_max, row_end, pass;
	logic signed [31:0] new_max;
	logic [6:0]         new_label;
	logic [12:0]        sat_score;

	always_comb begin
		pos = frame_start ? 8'd0 : row_pos_q;
		cnt = frame_start ? 16'd0 : boxes_q;
		if (cfg.class_count == 8'd0) begin
			cc = 8'd1;
		end else if (cfg.class_count > 8'(dbd_pkg::MAX_CLASSES)) begin
			cc = 8'(dbd_pkg::MAX_CLASSES);
		end else begin
			cc = cfg.class_count;
		end
		cc_m1     = cc - 8'd1;
		k         = pos - 8'd4;
		is_box    = pos < 8'd4;
		take_max  = (k == 8'd0) || (value > run_max_q);
		new_max   = take_max ? value : run_max_q;
		new_label = take_max ? k[6:0] : run_label_q;
		row_end   = !is_box && !(k < cc_m1);
		pass      = row_end && (new_max >= $signed({19'd0, cfg.min_score}))
			&& (cnt < cfg.box_limit);
	end

	assign job_valid       = in_beat && pass;
	assign job.center_x    = cx_q;
	assign job.center_y    = cy_q;
	assign job.box_width   = w_q;
	assign job.box_height  = h_q;
	assign job.class_label = new_label;
	assign job.best_score  = sat_score;
	always_comb begin
		if (new_max < 0) begin
			sat_score = 13'd0;
		end else if (new_max > 32'sd4096) begin
			sat_score = 13'd4096;
		end else begin
			sat_score = new_max[12:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q   <= '0;
			boxes_q     <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			w_q         <= '0;
			h_q         <= '0;
			run_max_q   <= '0;
			run_label_q <= '0;
		end else if (in_beat) begin
			boxes_q <= cnt + {15'd0, pass};
			if (is_box) begin
				case (pos[1:0])
					2'd0: cx_q <= value;
					2'd1: cy_q <= value;
					2'd2: w_q <= value;
					default: h_q <= value;
				endcase
				row_pos_q <= pos + 8'd1;
			end else begin
				run_max_q   <= new_max;
				run_label_q <= new_label;
				row_pos_q   <= row_end ? 8'd0 : pos + 8'd1;
			end
		end
	end

endmodule

/* rtl/core/dbd_job_queue.sv */
// ----------------------------------------------------------------------------
// dbd_job_queue
// short queue of box jobs between the row parser and the corner pipeline
// ----------------------------------------------------------------------------
module dbd_job_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dbd_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output dbd_pkg::job_t head
);

	dbd_pkg::job_t mem_q [dbd_pkg::JOB_DEPTH];
	logic [1:0]    wr_ptr_q, rd_ptr_q;
	logic [2:0]    count_q;

	assign full  = count_q == 3'(dbd_pkg::JOB_DEPTH);
	assign empty = count_q == 3'd0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {2'd0, push} - {2'd0, pop};
		end
	end

endmodule

/* rtl/core/dbd_back.sv */
// ----------------------------------------------------------------------------
// dbd_back
// corner pipeline: padding removal, inverse scale, clamp, result queue
// ----------------------------------------------------------------------------
module dbd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  dbd_pkg::cfg_t cfg,
	input  logic          job_ready,
	input  dbd_pkg::job_t job,
	output logic          job_take,
	input  logic          box_pop,
	output logic          box_empty,
	output dbd_pkg::box_t box
);

	localparam int DW = dbd_pkg::DW;

	// lanes: left, top, right, bottom
	logic signed [dbd_pkg::DW-1:0]  d_s1 [4];
	logic [12:0]                    score_s1, score_s2;
	logic [6:0]                     label_s1, label_s2;
	logic                           v_s1, v_s2;
	logic signed [dbd_pkg::PPW-1:0] pp_hi_s2 [4];
	logic [dbd_pkg::PPW-1:0]        pp_lo_s2 [4];
	logic [23:0]                    corner [4];

	dbd_pkg::box_t mem_q [dbd_pkg::BOX_DEPTH];
	logic [1:0]    wr_ptr_q, rd_ptr_q;
	logic [2:0]    count_q;

	logic signed [33:0] hx, hy;
	logic signed [dbd_pkg::DW-1:0] px, py;
	logic [12:0] size_w, size_h;
	logic [23:0] lim_w, lim_h;

	// room for every job in flight plus the one taken now
	assign job_take = job_ready
		&& ((count_q + {2'd0, v_s1} + {2'd0, v_s2}) < 3'(dbd_pkg::BOX_DEPTH));

	always_comb begin
		hx = 34'(job.center_x) <<< 1;
		hy = 34'(job.center_y) <<< 1;
		px = $signed({10'd0, cfg.pad_x, 13'd0});
		py = $signed({10'd0, cfg.pad_y, 13'd0});
		size_w = (cfg.image_width == 13'd0) ? 13'd1
			: (cfg.image_width > 13'd4096) ? 13'd4096 : cfg.image_width;
		size_h = (cfg.image_height == 13'd0) ? 13'd1
			: (cfg.image_height > 13'd4096) ? 13'd4096 : cfg.image_height;
		lim_w = {12'(size_w - 13'd1), 12'd0};
		lim_h = {12'(size_h - 13'd1), 12'd0};
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			d_s1[0]  <= DW'(hx) - DW'(job.box_width) - px;
			d_s1[1]  <= DW'(hy) - DW'(job.box_height) - py;
			d_s1[2]  <= DW'(hx) + DW'(job.box_width) - px;
			d_s1[3]  <= DW'(hy) + DW'(job.box_height) - py;
			score_s1 <= job.best_score;
			label_s1 <= job.class_label;
		end
		if (v_s1) begin
			score_s2 <= score_s1;
			label_s2 <= label_s1;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		logic signed [dbd_pkg::PW-1:0] p;
		logic [dbd_pkg::PW-18:0]       r;
		logic [23:0]                   lim;

		// split product, low part unsigned, high part signed
		always_ff @(posedge clk) begin
			if (v_s1) begin
				pp_lo_s2[i] <= dbd_pkg::PPW'(d_s1[i][17:0]) * dbd_pkg::PPW'(cfg.inv_scale);
				pp_hi_s2[i] <= $signed(d_s1[i][DW-1:18]) * $signed({1'b0, cfg.inv_scale});
			end
		end

		always_comb begin
			lim = (i == 0 || i == 2) ? lim_w : lim_h;
			p   = (dbd_pkg::PW'(pp_hi_s2[i]) <<< 18)
				+ $signed({18'd0, pp_lo_s2[i]});
			r   = p[dbd_pkg::PW-1:17];
			if (p[dbd_pkg::PW-1] || p == '0) begin
				corner[i] = 24'd0;
			end else if (r > {19'd0, lim}) begin
				corner[i] = lim;
			end else begin
				corner[i] = r[23:0];
			end
		end
	end

	// result queue
	assign box_empty = count_q == 3'd0;
	assign box       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (v_s2) begin
			mem_q[wr_ptr_q] <= '{left: corner[0], top: corner[1], right: corner[2],
				bottom: corner[3], best_score: score_s2, class_label: label_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			v_s1 <= job_take;
			v_s2 <= v_s1;
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (box_pop && !box_empty) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {2'd0, v_s2} - {2'd0, box_pop && !box_empty};
		end
	end

endmodule

/* rtl/core/detection_box_decode_unit.sv */
// ----------------------------------------------------------------------------
// detection_box_decode_unit
// streams detector rows one value a beat and emits clamped boxes
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  input    | push / full            | value, frame_start
//  result   | pop / empty            | left, top, right, bottom, best_score,
//           |                        | class_label
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one input beat per cycle while full is low; a box shows on the result
// ports once its row's last class score has gone through the parser, the
// job queue, the difference and partial product stages and the result queue
// reset clears row position, box count and queues; registers take defaults
// full rises only while the four-entry job queue is full, which needs the
// result side stalled; the result queue holds four boxes
// ----------------------------------------------------------------------------
module detection_box_decode_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] value,
	input  logic               frame_start,
	input  logic               pop,
	output logic               empty,
	output logic [23:0]        left,
	output logic [23:0]        top,
	output logic [23:0]        right,
	output logic [23:0]        bottom,
	output logic [12:0]        best_score,
	output logic [6:0]         class_label,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	dbd_pkg::cfg_t cfg_q;
	dbd_pkg::job_t new_job, head_job;
	dbd_pkg::box_t box;
	logic          in_beat, job_valid, jq_empty, job_take;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_score    <= 13'd1024;
			cfg_q.inv_scale    <= 24'd65536;
			cfg_q.pad_x        <= 12'd0;
			cfg_q.pad_y        <= 12'd0;
			cfg_q.image_width  <= 13'd640;
			cfg_q.image_height <= 13'd640;
			cfg_q.class_count  <= 8'd80;
			cfg_q.box_limit    <= 16'd30000;
		end else if (cfg_valid) begin
			case (cfg_index)
				dbd_pkg::CFG_MIN_SCORE:    cfg_q.min_score <= cfg_data[12:0];
				dbd_pkg::CFG_INV_SCALE:    cfg_q.inv_scale <= cfg_data[23:0];
				dbd_pkg::CFG_PAD_X:        cfg_q.pad_x <= cfg_data[11:0];
				dbd_pkg::CFG_PAD_Y:        cfg_q.pad_y <= cfg_data[11:0];
				dbd_pkg::CFG_IMAGE_WIDTH:  cfg_q.image_width <= cfg_data[12:0];
				dbd_pkg::CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[12:0];
				dbd_pkg::CFG_CLASS_COUNT:  cfg_q.class_count <= cfg_data[7:0];
				dbd_pkg::CFG_BOX_LIMIT:    cfg_q.box_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input beat taken while the job queue has room
	assign in_beat = push && !full;

	// row parser and best class tracking
	dbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_beat    (in_beat),
		.value      (value),
		.frame_start(frame_start),
		.cfg        (cfg_q),
		.job_valid  (job_valid),
		.job        (new_job)
	);

	// decouples the parser from the corner pipeline
	dbd_job_queue u_job_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_valid),
		.push_job(new_job),
		.pop     (job_take),
		.full    (full),
		.empty   (jq_empty),
		.head    (head_job)
	);

	// corner arithmetic and result queue
	dbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job_ready(!jq_empty),
		.job      (head_job),
		.job_take (job_take),
		.box_pop  (pop),
		.box_empty(empty),
		.box      (box)
	);

	assign left        = box.left;
	assign top         = box.top;
	assign right       = box.right;
	assign bottom      = box.bottom;
	assign best_score  = box.best_score;
	assign class_label = box.class_label;

endmodule
